### rtl/byte_stream_tokenizer_top_macros.svh
// ----------------------------------------------------------------------------
// Byte stream tokenizer assertion macros
// Shorthands for the concurrent checks of the tokenizer top level.
// ----------------------------------------------------------------------------
`ifndef BYTE_STREAM_TOKENIZER_TOP_MACROS_SVH
`define BYTE_STREAM_TOKENIZER_TOP_MACROS_SVH

// same-cycle implication
`define BTOK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BTOK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/btok_pkg.sv
// ----------------------------------------------------------------------------
// Byte stream tokenizer package
// Token kinds, character codes, result and queue types shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package btok_pkg;

  // token kinds
  localparam logic [3:0] K_LPAREN  = 4'd0;
  localparam logic [3:0] K_RPAREN  = 4'd1;
  localparam logic [3:0] K_PLUS    = 4'd2;
  localparam logic [3:0] K_MINUS   = 4'd3;
  localparam logic [3:0] K_STAR    = 4'd4;
  localparam logic [3:0] K_SLASH   = 4'd5;
  localparam logic [3:0] K_GREATER = 4'd6;
  localparam logic [3:0] K_EQUAL   = 4'd7;
  localparam logic [3:0] K_SEMI    = 4'd8;
  localparam logic [3:0] K_LESS    = 4'd9;
  localparam logic [3:0] K_NUMBER  = 4'd10;
  localparam logic [3:0] K_IDENT   = 4'd11;
  localparam logic [3:0] K_KEYWORD = 4'd12;
  localparam logic [3:0] K_EOF     = 4'd13;
  localparam logic [3:0] K_BAD     = 4'd14;
  localparam logic [3:0] K_OPEN    = 4'd15;

  // character codes
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LESS    = 8'h3C;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_V       = 8'h76;

  localparam int IN_TDATA_W  = 8;
  localparam int RES_BITS    = 52;
  localparam int OUT_TDATA_W = 56;
  localparam logic [15:0] LINE_MAX = 16'hFFFF;

  // result queue
  localparam int QDEPTH = 8;
  localparam int QAW    = 3;
  localparam int MAX_PUSH = 3;

  typedef struct packed {
    logic        last;
    logic [15:0] line;
    logic [15:0] length;
    logic [15:0] start;
    logic [3:0]  kind;
  } result_t;

  typedef struct packed {
    logic [1:0]        cnt;
    result_t [2:0]     item;
  } push_t;

  // {hit, kind} for single-character operators
  function automatic logic [4:0] op_kind(input logic [7:0] c);
    logic [4:0] r;
    case (c)
      CH_LPAREN:  r = {1'b1, K_LPAREN};
      CH_RPAREN:  r = {1'b1, K_RPAREN};
      CH_PLUS:    r = {1'b1, K_PLUS};
      CH_MINUS:   r = {1'b1, K_MINUS};
      CH_STAR:    r = {1'b1, K_STAR};
      CH_SLASH:   r = {1'b1, K_SLASH};
      CH_GREATER: r = {1'b1, K_GREATER};
      CH_EQUAL:   r = {1'b1, K_EQUAL};
      CH_SEMI:    r = {1'b1, K_SEMI};
      default:    r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_UNDER);
  endfunction

endpackage

`default_nettype wire

### rtl/btok_scan.sv
// ----------------------------------------------------------------------------
// Byte stream tokenizer scanner
// Input register, scan state and per-byte token decision (up to three results).
// ----------------------------------------------------------------------------
`default_nettype none

module btok_scan #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire logic [7:0]          load_byte,
  input  wire logic                load_final,
  output logic                     stage_valid,
  output btok_pkg::push_t          push
);

  localparam int P  = POSITION_BITS;
  localparam int LW = (P > 16) ? P : 16;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_NUMBER  = 3'd1;
  localparam logic [2:0] MODE_IDENT   = 3'd2;
  localparam logic [2:0] MODE_LESS    = 3'd3;
  localparam logic [2:0] MODE_COMMENT = 3'd4;
  localparam logic [2:0] MODE_DASH    = 3'd5;

  logic          valid_r;
  logic [7:0]    byte_r;
  logic          final_r;

  logic [2:0]    mode_r, mode_nxt;
  logic [P-1:0]  pos_r, pos_nxt;
  logic [P-1:0]  tbeg_r, tbeg_nxt;
  logic [15:0]   line_r, line_nxt;
  logic [1:0]    kp_r, kp_nxt;

  logic          used;
  logic [1:0]    n;
  logic [4:0]    op;
  logic [15:0]   line_inc;
  logic [P-1:0]  next_pos;
  btok_pkg::result_t [2:0] item;

  function automatic btok_pkg::result_t mk(input logic [3:0] kind,
                                           input logic [P-1:0] start,
                                           input logic [P-1:0] len,
                                           input logic [15:0] line,
                                           input logic last);
    btok_pkg::result_t r;
    logic [LW-1:0] len_w;
    logic [LW-1:0] start_w;
    len_w    = LW'(len);
    start_w  = LW'(start);
    r.kind   = kind;
    r.start  = start_w[15:0];
    r.length = (len_w > LW'(btok_pkg::LINE_MAX)) ? btok_pkg::LINE_MAX : len_w[15:0];
    r.line   = line;
    r.last   = last;
    return r;
  endfunction

  function automatic logic [3:0] word_kind(input logic [1:0] kp);
    return (kp == 2'd2) ? btok_pkg::K_KEYWORD : btok_pkg::K_IDENT;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= load_byte;
      final_r <= load_final;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    tbeg_nxt = tbeg_r;
    line_nxt = line_r;
    kp_nxt   = kp_r;
    used     = 1'b0;
    n        = 2'd0;
    item     = '0;
    op       = btok_pkg::op_kind(byte_r);
    line_inc = (line_r != btok_pkg::LINE_MAX) ? line_r + 16'd1 : line_r;
    next_pos = pos_r + P'(1);

    case (mode_r)
      MODE_NUMBER: begin
        if (btok_pkg::is_digit(byte_r)) begin
          used = 1'b1;
        end else begin
          item[0]  = mk(btok_pkg::K_NUMBER, tbeg_r, pos_r - tbeg_r, line_r, 1'b0);
          n        = 2'd1;
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_IDENT: begin
        if (btok_pkg::is_alpha(byte_r) || btok_pkg::is_digit(byte_r)) begin
          kp_nxt = ((kp_r == 2'd1) && (byte_r == btok_pkg::CH_UNDER)) ? 2'd2 : 2'd0;
          used   = 1'b1;
        end else begin
          item[0]  = mk(word_kind(kp_r), tbeg_r, pos_r - tbeg_r, line_r, 1'b0);
          n        = 2'd1;
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_LESS: begin
        if (byte_r == btok_pkg::CH_MINUS) begin
          mode_nxt = MODE_COMMENT;
          used     = 1'b1;
        end else begin
          item[0]  = mk(btok_pkg::K_LESS, tbeg_r, P'(1), line_r, 1'b0);
          n        = 2'd1;
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_COMMENT: begin
        if (byte_r == btok_pkg::CH_MINUS) begin
          mode_nxt = MODE_DASH;
        end else if (byte_r == btok_pkg::CH_NL) begin
          line_nxt = line_inc;
        end
        used = 1'b1;
      end
      MODE_DASH: begin
        if (byte_r == btok_pkg::CH_GREATER) begin
          mode_nxt = MODE_IDLE;
        end else if (byte_r == btok_pkg::CH_MINUS) begin
          mode_nxt = MODE_DASH;
        end else begin
          if (byte_r == btok_pkg::CH_NL) begin
            line_nxt = line_inc;
          end
          mode_nxt = MODE_COMMENT;
        end
        used = 1'b1;
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase

    if (!used) begin
      if (op[4]) begin
        item[n] = mk(op[3:0], pos_r, P'(1), line_r, 1'b0);
        n       = n + 2'd1;
      end else if (byte_r == btok_pkg::CH_LESS) begin
        mode_nxt = MODE_LESS;
        tbeg_nxt = pos_r;
      end else if ((byte_r == btok_pkg::CH_SPACE) || (byte_r == btok_pkg::CH_TAB) ||
                   (byte_r == btok_pkg::CH_CR)) begin
        mode_nxt = mode_nxt;
      end else if (byte_r == btok_pkg::CH_NL) begin
        line_nxt = line_inc;
      end else if (btok_pkg::is_digit(byte_r)) begin
        mode_nxt = MODE_NUMBER;
        tbeg_nxt = pos_r;
      end else if (btok_pkg::is_alpha(byte_r)) begin
        mode_nxt = MODE_IDENT;
        tbeg_nxt = pos_r;
        kp_nxt   = (byte_r == btok_pkg::CH_V) ? 2'd1 : 2'd0;
      end else begin
        item[n] = mk(btok_pkg::K_BAD, pos_r, P'(1), line_r, 1'b0);
        n       = n + 2'd1;
      end
    end

    pos_nxt = next_pos;

    if (final_r) begin
      case (mode_nxt)
        MODE_NUMBER: begin
          item[n] = mk(btok_pkg::K_NUMBER, tbeg_nxt, next_pos - tbeg_nxt, line_nxt, 1'b0);
          n       = n + 2'd1;
        end
        MODE_IDENT: begin
          item[n] = mk(word_kind(kp_nxt), tbeg_nxt, next_pos - tbeg_nxt, line_nxt, 1'b0);
          n       = n + 2'd1;
        end
        MODE_LESS: begin
          item[n] = mk(btok_pkg::K_LESS, tbeg_nxt, P'(1), line_nxt, 1'b0);
          n       = n + 2'd1;
        end
        MODE_COMMENT, MODE_DASH: begin
          item[n] = mk(btok_pkg::K_OPEN, tbeg_nxt, next_pos - tbeg_nxt, line_nxt, 1'b0);
          n       = n + 2'd1;
        end
        default: begin
          n = n;
        end
      endcase
      item[n]  = mk(btok_pkg::K_EOF, next_pos, '0, line_nxt, 1'b1);
      n        = n + 2'd1;
      // start over for the next source
      mode_nxt = MODE_IDLE;
      pos_nxt  = '0;
      tbeg_nxt = '0;
      line_nxt = 16'd1;
      kp_nxt   = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      pos_r  <= '0;
      tbeg_r <= '0;
      line_r <= 16'd1;
      kp_r   <= 2'd0;
    end else if (valid_r) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      tbeg_r <= tbeg_nxt;
      line_r <= line_nxt;
      kp_r   <= kp_nxt;
    end
  end

  assign stage_valid = valid_r;
  assign push.cnt    = valid_r ? n : 2'd0;
  assign push.item   = item;

endmodule

`default_nettype wire

### rtl/btok_queue.sv
// ----------------------------------------------------------------------------
// Byte stream tokenizer result queue
// Takes up to three results a cycle, hands out one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module btok_queue (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire btok_pkg::push_t               push,
  output logic [btok_pkg::QAW:0]             level,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output btok_pkg::result_t                  out_item
);

  localparam int AW = btok_pkg::QAW;

  btok_pkg::result_t mem [btok_pkg::QDEPTH];

  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          pop;

  assign pop        = out_valid && out_ready;
  assign wr_ptr_nxt = wr_ptr_r + AW'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + AW'(pop);
  assign count_nxt  = count_r + (AW+1)'(push.cnt) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < btok_pkg::MAX_PUSH; i++) begin
      if (2'(i) < push.cnt) begin
        mem[wr_ptr_r + AW'(i)] <= push.item[i];
      end
    end
  end

  assign level     = count_r;
  assign out_valid = (count_r != '0);
  assign out_item  = mem[rd_ptr_r];

endmodule

`default_nettype wire

### rtl/byte_stream_tokenizer_top.sv
// ----------------------------------------------------------------------------
// Byte stream tokenizer
// Streaming lexical scanner: one source byte in, tokens out.
// ----------------------------------------------------------------------------
// Takes one source byte per cycle and reports tokens (kind, start offset,
// length, line) on the result stream, with tlast on the end-of-file token.
// An accepted byte is registered, decided in the following cycle and its up
// to three tokens land in an eight-entry result queue, so a token passes the
// byte register and the queue before it appears on the output. The output
// drains one token per ready cycle; the input takes a byte every cycle as long
// as the queue, counting the byte in flight, still has room for three tokens.
`default_nettype none

`include "byte_stream_tokenizer_top_macros.svh"

module byte_stream_tokenizer_top #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [btok_pkg::IN_TDATA_W-1:0]   in_tdata,   // source_byte
  input  wire logic                              in_tlast,   // final_byte
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // token_kind[3:0], token_start[19:4], token_length[35:20], token_line[51:36]
  output logic [btok_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                   out_tlast   // last_result
);

  logic                     stage_valid;
  logic                     load;
  btok_pkg::push_t          push;
  logic [btok_pkg::QAW:0]   q_level;
  logic [btok_pkg::QAW+1:0] committed;
  btok_pkg::result_t        q_item;

  assign committed = (btok_pkg::QAW+2)'(q_level) +
                     (stage_valid ? (btok_pkg::QAW+2)'(btok_pkg::MAX_PUSH) : '0);
  assign in_tready = (committed <= (btok_pkg::QAW+2)'(btok_pkg::QDEPTH - btok_pkg::MAX_PUSH));
  assign load      = in_tvalid && in_tready;

  btok_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .load_byte  (in_tdata),
    .load_final (in_tlast),
    .stage_valid(stage_valid),
    .push       (push)
  );

  btok_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .level    (q_level),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_item (q_item)
  );

  assign out_tdata = {(btok_pkg::OUT_TDATA_W - btok_pkg::RES_BITS)'(0),
                      q_item.line, q_item.length, q_item.start, q_item.kind};
  assign out_tlast = q_item.last;

  `BTOK_ASSERT_NOW(a_queue_bound, 1'b1, q_level <= btok_pkg::QDEPTH, "result queue overflow")
  `BTOK_ASSERT_NOW(a_push_gated, !stage_valid, push.cnt == 2'd0,
                   "push without a byte in stage")
  `BTOK_ASSERT_NOW(a_last_is_eof, out_tvalid && out_tlast,
                   out_tdata[3:0] == btok_pkg::K_EOF, "tlast on a token other than end of file")
  `BTOK_ASSERT_NEXT(a_load_stages, load, stage_valid, "accepted byte did not reach the stage")

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stream tokenizer testbench
// Streams source text into the tokenizer and checks every token against a
// scanner modeled in the testbench: directed sources, random well-formed and
// broken sources under three idling mixes, and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PRINT_LIMIT    = 50;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_NUMBER, SCAN_IDENT, SCAN_LESS, SCAN_COMMENT, SCAN_DASH
  } scan_mode_t;

  typedef enum logic [1:0] {KW_NONE, KW_V, KW_VU} kw_state_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [btok_pkg::IN_TDATA_W-1:0]  in_tdata = '0;   // source_byte
  logic                             in_tlast = 1'b0; // final_byte
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  // token_kind[3:0], token_start[19:4], token_length[35:20], token_line[51:36]
  logic [btok_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tlast;       // last_result

  byte_stream_tokenizer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                mismatches = 0;
  int                bytes_sent = 0;
  int                idle_cycles = 0;
  int                hold_req = 0;
  int                hold_ack = 0;
  int                hold_left = 0;
  btok_pkg::result_t token_queue[$];
  logic [7:0]        text_buf[$];

  // scanner state
  scan_mode_t  scan_mode = SCAN_IDLE;
  kw_state_t   kw_state = KW_NONE;
  logic [15:0] scan_pos = '0;
  logic [15:0] tok_begin = '0;
  logic [15:0] line_no = 16'd1;

  task automatic report_error(input string msg);
    if (mismatches < PRINT_LIMIT)
      $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic scan_reset();
    scan_mode = SCAN_IDLE;
    kw_state  = KW_NONE;
    scan_pos  = '0;
    tok_begin = '0;
    line_no   = 16'd1;
  endtask

  task automatic bump_line();
    if (line_no != btok_pkg::LINE_MAX)
      line_no++;
  endtask

  task automatic emit_token(input logic [3:0] kind, input logic [15:0] start,
                            input logic [15:0] len, input logic last);
    btok_pkg::result_t r;
    r.kind   = kind;
    r.start  = start;
    r.length = len;
    r.line   = line_no;
    r.last   = last;
    token_queue.push_back(r);
  endtask

  function automatic logic single_op(input logic [7:0] c, output logic [3:0] k);
    single_op = 1'b1;
    k = btok_pkg::K_LPAREN;
    case (c)
      btok_pkg::CH_LPAREN:  k = btok_pkg::K_LPAREN;
      btok_pkg::CH_RPAREN:  k = btok_pkg::K_RPAREN;
      btok_pkg::CH_PLUS:    k = btok_pkg::K_PLUS;
      btok_pkg::CH_MINUS:   k = btok_pkg::K_MINUS;
      btok_pkg::CH_STAR:    k = btok_pkg::K_STAR;
      btok_pkg::CH_SLASH:   k = btok_pkg::K_SLASH;
      btok_pkg::CH_GREATER: k = btok_pkg::K_GREATER;
      btok_pkg::CH_EQUAL:   k = btok_pkg::K_EQUAL;
      btok_pkg::CH_SEMI:    k = btok_pkg::K_SEMI;
      default:              single_op = 1'b0;
    endcase
  endfunction

  function automatic logic [3:0] word_kind();
    return (kw_state == KW_VU) ? btok_pkg::K_KEYWORD : btok_pkg::K_IDENT;
  endfunction

  task automatic scan_byte(input logic [7:0] c, input logic fin);
    logic        used;
    logic        is_dig;
    logic        is_let;
    logic [3:0]  k;
    logic [15:0] nxt;
    is_dig = (c >= "0") && (c <= "9");
    is_let = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
             (c == btok_pkg::CH_UNDER);
    used = 1'b0;
    case (scan_mode)
      SCAN_NUMBER: begin
        if (is_dig) begin
          used = 1'b1;
        end else begin
          emit_token(btok_pkg::K_NUMBER, tok_begin, scan_pos - tok_begin, 1'b0);
          scan_mode = SCAN_IDLE;
        end
      end
      SCAN_IDENT: begin
        if (is_let || is_dig) begin
          kw_state = (kw_state == KW_V && c == btok_pkg::CH_UNDER) ? KW_VU : KW_NONE;
          used = 1'b1;
        end else begin
          emit_token(word_kind(), tok_begin, scan_pos - tok_begin, 1'b0);
          scan_mode = SCAN_IDLE;
        end
      end
      SCAN_LESS: begin
        if (c == btok_pkg::CH_MINUS) begin
          scan_mode = SCAN_COMMENT;
          used = 1'b1;
        end else begin
          emit_token(btok_pkg::K_LESS, tok_begin, 16'd1, 1'b0);
          scan_mode = SCAN_IDLE;
        end
      end
      SCAN_COMMENT: begin
        if (c == btok_pkg::CH_MINUS)
          scan_mode = SCAN_DASH;
        else if (c == btok_pkg::CH_NL)
          bump_line();
        used = 1'b1;
      end
      SCAN_DASH: begin
        if (c == btok_pkg::CH_GREATER) begin
          scan_mode = SCAN_IDLE;
        end else if (c != btok_pkg::CH_MINUS) begin
          if (c == btok_pkg::CH_NL)
            bump_line();
          scan_mode = SCAN_COMMENT;
        end
        used = 1'b1;
      end
      default: scan_mode = SCAN_IDLE;
    endcase

    if (!used) begin
      if (single_op(c, k)) begin
        emit_token(k, scan_pos, 16'd1, 1'b0);
      end else if (c == btok_pkg::CH_LESS) begin
        scan_mode = SCAN_LESS;
        tok_begin = scan_pos;
      end else if (c == btok_pkg::CH_SPACE || c == btok_pkg::CH_TAB ||
                   c == btok_pkg::CH_CR) begin
        // skip whitespace
      end else if (c == btok_pkg::CH_NL) begin
        bump_line();
      end else if (is_dig) begin
        scan_mode = SCAN_NUMBER;
        tok_begin = scan_pos;
      end else if (is_let) begin
        scan_mode = SCAN_IDENT;
        tok_begin = scan_pos;
        kw_state  = (c == btok_pkg::CH_V) ? KW_V : KW_NONE;
      end else begin
        emit_token(btok_pkg::K_BAD, scan_pos, 16'd1, 1'b0);
      end
    end

    nxt = scan_pos + 16'd1;
    scan_pos = nxt;

    if (fin) begin
      case (scan_mode)
        SCAN_NUMBER:  emit_token(btok_pkg::K_NUMBER, tok_begin, nxt - tok_begin, 1'b0);
        SCAN_IDENT:   emit_token(word_kind(), tok_begin, nxt - tok_begin, 1'b0);
        SCAN_LESS:    emit_token(btok_pkg::K_LESS, tok_begin, 16'd1, 1'b0);
        SCAN_COMMENT,
        SCAN_DASH:    emit_token(btok_pkg::K_OPEN, tok_begin, nxt - tok_begin, 1'b0);
        default: ;
      endcase
      emit_token(btok_pkg::K_EOF, nxt, 16'd0, 1'b1);
      scan_reset();
    end
  endtask

  // hold valid high until the transaction completes
  task automatic send_byte(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= fin;
    do @(posedge clk); while (in_tready !== 1'b1);
    scan_byte(c, fin);
    bytes_sent++;
  endtask

  task automatic send_string(input string s, input logic fin_last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], fin_last && (i == s.len() - 1));
  endtask

  task automatic send_text();
    foreach (text_buf[i])
      send_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  function automatic logic [7:0] random_op();
    case ($urandom_range(8))
      0:       return btok_pkg::CH_LPAREN;
      1:       return btok_pkg::CH_RPAREN;
      2:       return btok_pkg::CH_PLUS;
      3:       return btok_pkg::CH_MINUS;
      4:       return btok_pkg::CH_STAR;
      5:       return btok_pkg::CH_SLASH;
      6:       return btok_pkg::CH_GREATER;
      7:       return btok_pkg::CH_EQUAL;
      default: return btok_pkg::CH_SEMI;
    endcase
  endfunction

  function automatic logic [7:0] random_word_char();
    case ($urandom_range(3))
      0:       return 8'("a" + $urandom_range(25));
      1:       return 8'("A" + $urandom_range(25));
      2:       return 8'("0" + $urandom_range(9));
      default: return btok_pkg::CH_UNDER;
    endcase
  endfunction

  function automatic logic [7:0] random_bad();
    if ($urandom_range(1))
      return 8'($urandom_range(128, 255));
    case ($urandom_range(6))
      0:       return 8'h00;
      1:       return 8'h7F;
      2:       return "!";
      3:       return "#";
      4:       return "@";
      5:       return "[";
      default: return "~";
    endcase
  endfunction

  task automatic add_random_lexeme();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 20) begin
      text_buf.push_back(random_op());
    end else if (pick < 35) begin
      n = $urandom_range(1, 4);
      repeat (n) text_buf.push_back(8'("0" + $urandom_range(9)));
    end else if (pick < 55) begin
      case ($urandom_range(3))
        0: begin
          text_buf.push_back(btok_pkg::CH_V);
          text_buf.push_back(btok_pkg::CH_UNDER);
        end
        1: text_buf.push_back(btok_pkg::CH_V);
        2: begin
          text_buf.push_back(btok_pkg::CH_V);
          text_buf.push_back(btok_pkg::CH_UNDER);
          text_buf.push_back(random_word_char());
        end
        default: begin
          case ($urandom_range(2))
            0:       text_buf.push_back(8'("a" + $urandom_range(25)));
            1:       text_buf.push_back(8'("A" + $urandom_range(25)));
            default: text_buf.push_back(btok_pkg::CH_UNDER);
          endcase
          n = $urandom_range(0, 5);
          repeat (n) text_buf.push_back(random_word_char());
        end
      endcase
      if ($urandom_range(1))
        text_buf.push_back(btok_pkg::CH_SPACE);
    end else if (pick < 70) begin
      case ($urandom_range(3))
        0:       text_buf.push_back(btok_pkg::CH_SPACE);
        1:       text_buf.push_back(btok_pkg::CH_TAB);
        2:       text_buf.push_back(btok_pkg::CH_CR);
        default: text_buf.push_back(btok_pkg::CH_NL);
      endcase
    end else if (pick < 82) begin
      text_buf.push_back(btok_pkg::CH_LESS);
      text_buf.push_back(btok_pkg::CH_MINUS);
      n = $urandom_range(0, 6);
      repeat (n) begin
        case ($urandom_range(5))
          0:       text_buf.push_back("a");
          1:       text_buf.push_back(btok_pkg::CH_MINUS);
          2:       text_buf.push_back(btok_pkg::CH_NL);
          3:       text_buf.push_back(btok_pkg::CH_GREATER);
          4:       text_buf.push_back(btok_pkg::CH_LESS);
          default: text_buf.push_back(btok_pkg::CH_SPACE);
        endcase
      end
      text_buf.push_back(btok_pkg::CH_MINUS);
      text_buf.push_back(btok_pkg::CH_GREATER);
    end else if (pick < 90) begin
      text_buf.push_back(btok_pkg::CH_LESS);
    end else begin
      text_buf.push_back(random_bad());
    end
  endtask

  task automatic test_directed();
    send_idle_pct = 9;
    recv_idle_pct = 81;
    send_string("()+-*/>=;<1", 1'b1);
    send_string("v_ ", 1'b0);
    send_byte(btok_pkg::CH_TAB, 1'b0);
    send_byte(btok_pkg::CH_CR, 1'b0);
    send_string("<-\n--x->", 1'b0);
    send_byte(8'h00, 1'b1);
    send_string("<-", 1'b1);
  endtask

  task automatic test_random_text(input int snd_pct, input int rcv_pct, input int n_bytes);
    int stop_at;
    int target;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      text_buf.delete();
      target = $urandom_range(1, 30);
      while (text_buf.size() < target)
        add_random_lexeme();
      // cut mid-token or mid-comment half the time
      if ($urandom_range(1))
        while (text_buf.size() > target)
          void'(text_buf.pop_back());
      send_text();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req++;
    for (int i = 0; i < 40; i++)
      send_byte(random_op(), i == 39);
  endtask

  // receiver: random stalls plus a counted hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_ack   <= hold_req;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    btok_pkg::result_t got;
    btok_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = btok_pkg::result_t'({out_tlast, out_tdata[btok_pkg::RES_BITS-1:0]});
      if (token_queue.size() == 0) begin
        report_error($sformatf("unexpected token kind %0d start %0d", got.kind, got.start));
      end else begin
        want = token_queue.pop_front();
        if (got.kind !== want.kind)
          report_error($sformatf("kind got %0d expected %0d", got.kind, want.kind));
        if (got.start !== want.start)
          report_error($sformatf("start got %0d expected %0d", got.start, want.start));
        if (got.length !== want.length)
          report_error($sformatf("length got %0d expected %0d", got.length, want.length));
        if (got.line !== want.line)
          report_error($sformatf("line got %0d expected %0d", got.line, want.line));
        if (got.last !== want.last)
          report_error($sformatf("last got %0d expected %0d", got.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_text(9, 81, 45);
    test_random_text(81, 9, 45);
    test_random_text(0, 0, 45);
    test_backpressure();
    in_tvalid <= 1'b0;
    while (token_queue.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

### byte_stream_tokenizer_top.f
+incdir+rtl
rtl/btok_pkg.sv
rtl/btok_scan.sv
rtl/btok_queue.sv
rtl/byte_stream_tokenizer_top.sv
tb/tb.sv
